[sv/vector_l2_normalizer_macros.svh]
// ----------------------------------------------------------------------------
// vector_l2_normalizer assertion macros
// concurrent checks on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef VECTOR_L2_NORMALIZER_MACROS_SVH
`define VECTOR_L2_NORMALIZER_MACROS_SVH

// consequent checked in the same cycle
`define VLN_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define VLN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vln_pkg.sv]
// ----------------------------------------------------------------------------
// vln_pkg
// widths, constants and shared types of the vector l2 normalizer
// ----------------------------------------------------------------------------
`default_nettype none

package vln_pkg;

	localparam int MAX_DIM_DEF = 64;

	localparam int ELEM_W   = 16;
	localparam int MAG_W    = 17;
	localparam int SUM_W    = 37;
	localparam int RECIP_W  = 41;
	localparam int ROOT_W   = 42;
	localparam int QUO_W    = 84;
	localparam int SUB_W    = 45;
	localparam int STEP_W   = 7;
	localparam int PROD_W   = 58;
	localparam int YM_W     = 33;

	// 2^82 / S takes one quotient bit per step, the root one bit per step
	localparam int DIV_STEPS  = 83;
	localparam int SQRT_STEPS = 42;

	localparam int ROUND_SHIFT = 25;
	localparam int RND_BIAS    = 1 << 24;
	localparam int SAT_POS     = 32767;
	localparam int SAT_NEG     = 32768;

	typedef struct packed {
		logic busy;
		logic done;
	} rsq_stat_t;

endpackage

`default_nettype wire

[sv/vln_sub.sv]
// ----------------------------------------------------------------------------
// vln_sub
// shared subtract and compare unit of the reciprocal root sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module vln_sub (
	input  wire logic [vln_pkg::SUB_W-1:0] a,
	input  wire logic [vln_pkg::SUB_W-1:0] b,
	output logic      [vln_pkg::SUB_W-1:0] diff,
	output logic                           ge
);

	logic [vln_pkg::SUB_W:0] full_w;

	assign full_w = {1'b0, a} - {1'b0, b};
	assign diff   = full_w[vln_pkg::SUB_W-1:0];
	// no borrow means a >= b
	assign ge     = ~full_w[vln_pkg::SUB_W];

endmodule

`default_nettype wire

[sv/vln_rsqrt.sv]
// ----------------------------------------------------------------------------
// vln_rsqrt
// rounded reciprocal square root: restoring divide of 2^82 by the sum,
// then a restoring integer square root, both on one shared subtractor
// ----------------------------------------------------------------------------
`default_nettype none

module vln_rsqrt (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             go,
	input  wire logic [vln_pkg::SUM_W-1:0]        sum,
	output vln_pkg::rsq_stat_t                    stat,
	output logic      [vln_pkg::RECIP_W-1:0]      recip
);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		SQRT,
		DONE
	} state_t;

	state_t                          state_q;
	logic [vln_pkg::STEP_W-1:0]      step_q;
	logic [vln_pkg::SUB_W-1:0]       rem_q;
	logic [vln_pkg::QUO_W-1:0]       quo_q;
	logic [vln_pkg::ROOT_W-1:0]      root_q;

	logic [vln_pkg::SUB_W-1:0]       sub_a;
	logic [vln_pkg::SUB_W-1:0]       sub_b;
	logic [vln_pkg::SUB_W-1:0]       sub_diff;
	logic                            sub_ge;
	logic                            div_bit;
	logic [vln_pkg::ROOT_W:0]        root_inc;

	// the dividend 2^82 has a single one, taken on the first step
	assign div_bit = (step_q == vln_pkg::STEP_W'(vln_pkg::DIV_STEPS - 1));

	always_comb begin
		if (state_q == SQRT) begin
			sub_a = {rem_q[vln_pkg::SUB_W-3:0], quo_q[vln_pkg::QUO_W-1 -: 2]};
			sub_b = {1'b0, root_q, 2'b01};
		end else begin
			sub_a = {rem_q[vln_pkg::SUB_W-2:0], div_bit};
			sub_b = vln_pkg::SUB_W'(sum);
		end
	end

	vln_sub u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	// largest odd t <= isqrt(q) gives r = (t + 1) / 2 = (root + 1) >> 1
	assign root_inc = {1'b0, root_q} + (vln_pkg::ROOT_W + 1)'(1);
	assign recip    = root_inc[vln_pkg::RECIP_W:1];

	assign stat.busy = (state_q != IDLE);
	assign stat.done = (state_q == DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			root_q  <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (go) begin
						rem_q   <= '0;
						quo_q   <= '0;
						root_q  <= '0;
						step_q  <= vln_pkg::STEP_W'(vln_pkg::DIV_STEPS - 1);
						state_q <= DIV;
					end
				end
				DIV: begin
					quo_q <= {quo_q[vln_pkg::QUO_W-2:0], sub_ge};
					if (step_q == '0) begin
						rem_q   <= '0;
						step_q  <= vln_pkg::STEP_W'(vln_pkg::SQRT_STEPS - 1);
						state_q <= SQRT;
					end else begin
						rem_q  <= sub_ge ? sub_diff : sub_a;
						step_q <= step_q - vln_pkg::STEP_W'(1);
					end
				end
				SQRT: begin
					rem_q  <= sub_ge ? sub_diff : sub_a;
					root_q <= {root_q[vln_pkg::ROOT_W-2:0], sub_ge};
					quo_q  <= {quo_q[vln_pkg::QUO_W-3:0], 2'b00};
					if (step_q == '0) begin
						state_q <= DONE;
					end else begin
						step_q <= step_q - vln_pkg::STEP_W'(1);
					end
				end
				DONE: begin
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/vln_store.sv]
// ----------------------------------------------------------------------------
// vln_store
// element memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module vln_store #(
	parameter int MAX_DIM = vln_pkg::MAX_DIM_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [$clog2(MAX_DIM)-1:0]        waddr,
	input  wire logic [vln_pkg::ELEM_W-1:0]        wdata,
	input  wire logic [$clog2(MAX_DIM)-1:0]        raddr,
	output logic      [vln_pkg::ELEM_W-1:0]        rdata
);

	logic [vln_pkg::ELEM_W-1:0] mem [MAX_DIM];
	logic [vln_pkg::ELEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/vector_l2_normalizer.sv]
// ----------------------------------------------------------------------------
// vector_l2_normalizer
// scales a vector of Q4.12 elements to unit length, results in Q1.15
// ----------------------------------------------------------------------------
// A word is taken at a clock edge with start high and busy low; element_value
// is one element, last_element closes the vector. Words that do not close
// the vector can come one per cycle, and busy stays low between them.
// On the closing word busy rises. The reciprocal root of the sum of squares
// runs on one shared 45-bit subtractor: a division of 2^82 by the sum, then
// a square root, both before the first result; an all-zero vector skips them.
// Then one result per cycle for each stored element, in arrival order, each
// marked by valid for exactly one cycle; last_result flags the final one and
// truncated flags a vector that had words beyond MAX_DIM dropped.
// busy falls in the cycle that shows the final result.
// Results are not held: the receiver must take each one as it appears.
// Reset clears the partial vector; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_l2_normalizer_macros.svh"

module vector_l2_normalizer #(
	parameter int MAX_DIM = vln_pkg::MAX_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [vln_pkg::ELEM_W-1:0]   element_value,
	input  wire logic                                last_element,
	output logic                                     valid,
	output logic signed      [vln_pkg::ELEM_W-1:0]   normalized_value,
	output logic                                     last_result,
	output logic                                     truncated
);

	localparam int AW = $clog2(MAX_DIM);
	localparam int CW = $clog2(MAX_DIM + 1);

	typedef enum logic [2:0] {
		ACC,
		KICK,
		CALC,
		DRAIN,
		FLUSH
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic [vln_pkg::SUM_W-1:0]       sum_q;
	logic                            ovf_q;
	logic [AW-1:0]                   rd_idx_q;
	logic [vln_pkg::RECIP_W-1:0]     recip_q;

	logic                            valid_s1;
	logic                            last_s1;
	logic                            valid_s2;
	logic                            last_s2;
	logic                            neg_s2;
	logic [vln_pkg::PROD_W-1:0]      prod_s2;

	logic                            valid_q;
	logic [vln_pkg::ELEM_W-1:0]      value_q;
	logic                            last_q;
	logic                            trunc_q;

	logic                            accept;
	logic                            store_we;
	logic signed [31:0]              sq_w;
	logic                            rd_last;
	logic                            rsq_go;
	vln_pkg::rsq_stat_t              rsq_stat;
	logic [vln_pkg::RECIP_W-1:0]     rsq_recip;
	logic [vln_pkg::ELEM_W-1:0]      rdata;
	logic [vln_pkg::MAG_W-1:0]       mag_w;
	logic [vln_pkg::PROD_W-1:0]      rnd_w;
	logic [vln_pkg::YM_W-1:0]        ym_w;
	logic [vln_pkg::YM_W-1:0]        lim_w;
	logic [vln_pkg::ELEM_W-1:0]      ysat_w;
	logic [vln_pkg::ELEM_W-1:0]      y_w;

	assign busy     = (state_q != ACC);
	assign accept   = start && !busy;
	assign store_we = accept && (count_q < CW'(MAX_DIM));
	assign sq_w     = element_value * element_value;
	assign rd_last  = (CW'(rd_idx_q) == count_q - CW'(1));
	assign rsq_go   = (state_q == KICK) && (sum_q != '0);

	vln_store #(
		.MAX_DIM (MAX_DIM)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (element_value),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	vln_rsqrt u_rsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (rsq_go),
		.sum    (sum_q),
		.stat   (rsq_stat),
		.recip  (rsq_recip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ACC;
			count_q  <= '0;
			sum_q    <= '0;
			ovf_q    <= 1'b0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= (state_q == DRAIN);
			last_s1  <= (state_q == DRAIN) && rd_last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			valid_q  <= valid_s2;
			unique case (state_q)
				ACC: begin
					if (accept) begin
						if (store_we) begin
							count_q <= count_q + CW'(1);
							sum_q   <= sum_q + vln_pkg::SUM_W'(sq_w[30:0]);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_element) begin
							state_q <= KICK;
						end
					end
				end
				KICK: begin
					rd_idx_q <= '0;
					// an all-zero vector skips the root and drains with a zero scale
					state_q  <= (sum_q == '0) ? DRAIN : CALC;
				end
				CALC: begin
					if (rsq_stat.done) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (rd_last) begin
						state_q <= FLUSH;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				FLUSH: begin
					if (valid_s2 && last_s2) begin
						count_q <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ACC;
					end
				end
				default: begin
					state_q <= ACC;
				end
			endcase
		end
	end

	// magnitude of the stored element, -32768 maps to 32768
	assign mag_w = rdata[vln_pkg::ELEM_W-1] ?
		(vln_pkg::MAG_W'(0) - {rdata[vln_pkg::ELEM_W-1], rdata}) : {1'b0, rdata};

	// round half away from zero, then saturate the magnitude by sign
	assign rnd_w  = prod_s2 + vln_pkg::PROD_W'(vln_pkg::RND_BIAS);
	assign ym_w   = rnd_w[vln_pkg::PROD_W-1:vln_pkg::ROUND_SHIFT];
	assign lim_w  = neg_s2 ? vln_pkg::YM_W'(vln_pkg::SAT_NEG) : vln_pkg::YM_W'(vln_pkg::SAT_POS);
	assign ysat_w = (ym_w > lim_w) ? lim_w[vln_pkg::ELEM_W-1:0] : ym_w[vln_pkg::ELEM_W-1:0];
	assign y_w    = neg_s2 ? (vln_pkg::ELEM_W'(0) - ysat_w) : ysat_w;

	always_ff @(posedge clk) begin
		if (state_q == KICK) begin
			recip_q <= '0;
		end else if (rsq_stat.done) begin
			recip_q <= rsq_recip;
		end
		prod_s2 <= vln_pkg::PROD_W'(mag_w) * vln_pkg::PROD_W'(recip_q);
		neg_s2  <= rdata[vln_pkg::ELEM_W-1];
		value_q <= y_w;
		last_q  <= last_s2;
		trunc_q <= ovf_q;
	end

	assign valid            = valid_q;
	assign normalized_value = value_q;
	assign last_result      = last_q;
	assign truncated        = trunc_q;

	`VLN_ASSERT_SAME(a_mid_result_busy, valid && !last_result, busy,
		"result before the final one shown while not busy")
	`VLN_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(MAX_DIM),
		"element count beyond store depth")
	`VLN_ASSERT_SAME(a_root_done_calc, rsq_stat.done, state_q == CALC,
		"reciprocal root finished outside the wait state")
	`VLN_ASSERT_SAME(a_root_idle_acc, state_q == ACC, !rsq_stat.busy,
		"reciprocal root running while taking words")
	`VLN_ASSERT_NEXT(a_close_busy, start && !busy && last_element, busy,
		"closing word did not raise busy")

endmodule

`default_nettype wire
